// ===== rtl/vmfb_pkg.sv =====
// Shared constants, codes and types for the VCDU / M-PDU frame builder.
package vmfb_pkg;

  localparam int ZONE_BYTES  = 882;
  localparam int HDR_BYTES   = 14;
  localparam int FRAME_BYTES = ZONE_BYTES + HDR_BYTES;
  localparam int CNT_W       = $clog2(ZONE_BYTES + 1);
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int ADDR_W      = $clog2(2 * ZONE_BYTES);
  localparam int PTR_W       = 11;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [PTR_W-1:0] NO_HEADER = 11'h7FF;
  localparam logic [7:0] SYNC_0 = 8'h1A;
  localparam logic [7:0] SYNC_1 = 8'hCF;
  localparam logic [7:0] SYNC_2 = 8'hFC;
  localparam logic [7:0] SYNC_3 = 8'h1D;
  localparam logic [1:0] VERSION_BITS = 2'b01;
  localparam logic [5:0] CHANNEL_RESET = 6'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SPACECRAFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL    = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // one result in flight between front and back
  typedef struct packed {
    logic       from_mem;
    logic [7:0] obyte;
    logic       ovalid;
    logic       olast;
    logic       acc;
  } job_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       frame_last;
    logic       accepted;
  } result_t;

endpackage

// ===== rtl/vmfb_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface vmfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source (output valid, operation, data_byte, packet_start, input ready);
  modport sink (input valid, operation, data_byte, packet_start, output ready);
endinterface

interface vmfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       frame_last;
  logic       accepted;

  modport source (output valid, out_byte, out_valid, frame_last, accepted, input ready);
  modport sink (input valid, out_byte, out_valid, frame_last, accepted, output ready);
endinterface

// ===== rtl/vmfb_front.sv =====
// Front end: request decode, zone bookkeeping, zone store and frame byte select.
module vmfb_front
  import vmfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_fire,
  input  logic [1:0]            req_op,
  input  logic [7:0]            req_data,
  input  logic                  req_start,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  job_v_r,
  output job_t                  job_r,
  output logic [7:0]            rdata_r
);

  logic [7:0]       zone_mem [2*ZONE_BYTES];

  logic [7:0]       sc_r;
  logic [5:0]       ch_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] ffh_r, ffh_nxt;
  logic [PTR_W-1:0] rfh_r, rfh_nxt;
  logic [CNT_W-1:0] rfc_r, rfc_nxt;
  logic             bank_r, bank_nxt;
  logic             rdy_r, rdy_nxt;
  logic             held_r, held_nxt;
  logic [IDX_W-1:0] emit_r, emit_nxt;
  logic [23:0]      fc_r, fc_nxt;
  logic             job_v_nxt;
  job_t             job_nxt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [IDX_W-1:0]  off;
  logic              in_data;
  logic [7:0]        hdr_byte;
  logic              do_close;
  logic              do_handover;
  op_t               op;

  assign op  = op_t'(req_op);
  assign off = emit_r - IDX_W'(HDR_BYTES);
  assign in_data = (emit_r >= IDX_W'(HDR_BYTES)) && (off < IDX_W'(rfc_r));
  assign waddr = bank_r ? ADDR_W'(ZONE_BYTES) + ADDR_W'(fill_r) : ADDR_W'(fill_r);
  assign raddr = !bank_r ? ADDR_W'(ZONE_BYTES) + ADDR_W'(off) : ADDR_W'(off);

  always_comb begin
    unique case (emit_r)
      IDX_W'(0):  hdr_byte = SYNC_0;
      IDX_W'(1):  hdr_byte = SYNC_1;
      IDX_W'(2):  hdr_byte = SYNC_2;
      IDX_W'(3):  hdr_byte = SYNC_3;
      IDX_W'(4):  hdr_byte = {VERSION_BITS, sc_r[7:2]};
      IDX_W'(5):  hdr_byte = {sc_r[1:0], ch_r};
      IDX_W'(6):  hdr_byte = fc_r[23:16];
      IDX_W'(7):  hdr_byte = fc_r[15:8];
      IDX_W'(8):  hdr_byte = fc_r[7:0];
      IDX_W'(12): hdr_byte = {5'd0, rfh_r[10:8]};
      IDX_W'(13): hdr_byte = rfh_r[7:0];
      default:    hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    fill_nxt    = fill_r;
    ffh_nxt     = ffh_r;
    rfh_nxt     = rfh_r;
    rfc_nxt     = rfc_r;
    bank_nxt    = bank_r;
    rdy_nxt     = rdy_r;
    held_nxt    = held_r;
    emit_nxt    = emit_r;
    fc_nxt      = fc_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    do_close    = 1'b0;
    do_handover = 1'b0;
    job_v_nxt   = req_fire;
    job_nxt     = '0;
    if (req_fire) begin
      case (op)
        OP_PUSH: begin
          if (!held_r && (fill_r < CNT_W'(ZONE_BYTES))) begin
            mem_we = 1'b1;
            if (req_start && (ffh_r == NO_HEADER)) begin
              ffh_nxt = PTR_W'(fill_r);
            end
            fill_nxt = fill_r + 1'b1;
            do_close = (fill_nxt == CNT_W'(ZONE_BYTES));
            job_nxt.acc = 1'b1;
          end
        end
        OP_FLUSH: begin
          if (!held_r) begin
            do_close = (fill_r != '0);
            job_nxt.acc = 1'b1;
          end
        end
        OP_READ: begin
          if (rdy_r) begin
            mem_re = in_data;
            job_nxt.from_mem = in_data;
            job_nxt.obyte = in_data ? 8'd0 : hdr_byte;
            job_nxt.ovalid = 1'b1;
            emit_nxt = emit_r + 1'b1;
            if (emit_r == IDX_W'(FRAME_BYTES - 1)) begin
              job_nxt.olast = 1'b1;
              emit_nxt = '0;
              fc_nxt = fc_r + 24'd1;
              rdy_nxt = 1'b0;
              do_handover = held_r;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_close) begin
      if (rdy_r) begin
        held_nxt = 1'b1;
      end else begin
        do_handover = 1'b1;
      end
    end
    if (do_handover) begin
      rfh_nxt  = ffh_nxt;
      rfc_nxt  = fill_nxt;
      bank_nxt = !bank_r;
      rdy_nxt  = 1'b1;
      held_nxt = 1'b0;
      fill_nxt = '0;
      ffh_nxt  = NO_HEADER;
      emit_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= '0;
      ch_r    <= CHANNEL_RESET;
      fill_r  <= '0;
      ffh_r   <= NO_HEADER;
      rfh_r   <= NO_HEADER;
      rfc_r   <= '0;
      bank_r  <= 1'b0;
      rdy_r   <= 1'b0;
      held_r  <= 1'b0;
      emit_r  <= '0;
      fc_r    <= '0;
      job_v_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_idx == REG_SPACECRAFT)) begin
        sc_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_idx == REG_CHANNEL)) begin
        ch_r <= cfg_wdata[5:0];
      end
      fill_r  <= fill_nxt;
      ffh_r   <= ffh_nxt;
      rfh_r   <= rfh_nxt;
      rfc_r   <= rfc_nxt;
      bank_r  <= bank_nxt;
      rdy_r   <= rdy_nxt;
      held_r  <= held_nxt;
      emit_r  <= emit_nxt;
      fc_r    <= fc_nxt;
      job_v_r <= job_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      zone_mem[waddr] <= req_data;
    end
    if (mem_re) begin
      rdata_r <= zone_mem[raddr];
    end
  end

endmodule

// ===== rtl/vmfb_back.sv =====
// Back end: result queue that merges store read data and drives the result channel.
module vmfb_back
  import vmfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_v,
  input  job_t       job,
  input  logic [7:0] rdata,
  output logic       credit_ok,
  output logic       res_valid,
  output result_t    res,
  input  logic       res_ready
);

  result_t              q_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 push, pop;
  result_t              push_res;

  assign push = job_v;
  assign pop  = res_valid && res_ready;

  assign push_res.out_byte   = job.from_mem ? rdata : job.obyte;
  assign push_res.out_valid  = job.ovalid;
  assign push_res.frame_last = job.olast;
  assign push_res.accepted   = job.acc;

  assign res_valid = (count_r != '0);
  assign res       = q_mem[rd_ptr_r];
  assign credit_ok = (count_r + FIFO_CW'(job_v)) < FIFO_CW'(FIFO_DEPTH);

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_res;
    end
  end

endmodule

// ===== rtl/vcdu_mpdu_frame_builder.sv =====
// Top level of the VCDU / M-PDU frame builder.
//
//   channel  direction  transfer content
//   in_ch    in         operation, data_byte, packet_start
//   out_ch   out        out_byte, out_valid, frame_last, accepted
//   cfg_*    in         register write, index 0 spacecraft_id, 1 channel_id
//
// One request per cycle while in_ch.ready is high. A result can transfer at the earliest once
// its request has passed the front-end job and store read registers, then the result queue.
// Synchronous active-low reset; the zone store is not cleared.
// in_ch.ready is low while the queued results plus the one in flight reach four.
module vcdu_mpdu_frame_builder
  import vmfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vmfb_in_if.sink               in_ch,
  vmfb_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic       job_v;
  job_t       job;
  logic [7:0] rdata;
  logic       credit_ok;
  logic       res_valid;
  result_t    res;
  logic       req_fire;

  assign in_ch.ready = credit_ok;
  assign req_fire    = in_ch.valid && credit_ok;

  vmfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (req_fire),
    .req_op    (in_ch.operation),
    .req_data  (in_ch.data_byte),
    .req_start (in_ch.packet_start),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .job_v_r   (job_v),
    .job_r     (job),
    .rdata_r   (rdata)
  );

  vmfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_v     (job_v),
    .job       (job),
    .rdata     (rdata),
    .credit_ok (credit_ok),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_ch.ready)
  );

  assign out_ch.valid      = res_valid;
  assign out_ch.out_byte   = res.out_byte;
  assign out_ch.out_valid  = res.out_valid;
  assign out_ch.frame_last = res.frame_last;
  assign out_ch.accepted   = res.accepted;

endmodule

// ===== rtl/vmfb_checker.sv =====
// Port-level checks for the frame builder, bound to the top level.
module vmfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_frame_last,
  input logic       out_accepted
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("no result two cycles after a request transfer");

  a_read_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_valid) |-> !out_accepted)
    else $error("frame byte result also flags accepted");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_byte == 8'd0) && !out_frame_last)
    else $error("non-read result carries frame data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_byte))
    else $error("stalled result dropped or changed");

endmodule

bind vcdu_mpdu_frame_builder vmfb_checker u_vmfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .out_byte_valid (out_ch.out_valid),
  .out_frame_last (out_ch.frame_last),
  .out_accepted   (out_ch.accepted)
);

// ===== dv/tb_vcdu_mpdu_frame_builder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the VCDU / M-PDU frame builder: random traffic against a predictor.
module tb_vcdu_mpdu_frame_builder;
  import vmfb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 20;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       start;
  } req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vmfb_in_if  in_ch ();
  vmfb_out_if out_ch ();

  vcdu_mpdu_frame_builder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t    frame_reqs[$];
  result_t due_results[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      queued = 0;
  int      errors = 0;
  int      cycles = 0;
  int      n_transfers = 0;
  int      n_frames = 0;
  int      n_refused = 0;

  // predicted builder state
  logic [7:0]       zone_mem [2*ZONE_BYTES];
  logic [CNT_W-1:0] fill_cnt = '0;
  logic [CNT_W-1:0] rdy_cnt = '0;
  logic [PTR_W-1:0] fill_ptr = NO_HEADER;
  logic [PTR_W-1:0] rdy_ptr = NO_HEADER;
  logic             fill_bank = 1'b0;
  logic             zone_ready = 1'b0;
  logic             zone_held = 1'b0;
  logic [IDX_W-1:0] emit_idx = '0;
  logic [23:0]      frame_seq = '0;
  logic [7:0]       scid = 8'd0;
  logic [5:0]       vcid = CHANNEL_RESET;

  task automatic hand_over();
    rdy_ptr    = fill_ptr;
    rdy_cnt    = fill_cnt;
    fill_bank  = ~fill_bank;
    zone_ready = 1'b1;
    zone_held  = 1'b0;
    fill_cnt   = '0;
    fill_ptr   = NO_HEADER;
    emit_idx   = '0;
  endtask

  task automatic close_zone();
    if (zone_ready) begin
      zone_held = 1'b1;
    end else begin
      hand_over();
    end
  endtask

  function automatic logic [7:0] frame_octet(input int idx);
    int rd_base;
    rd_base = fill_bank ? 0 : ZONE_BYTES;
    case (idx)
      0: return SYNC_0;
      1: return SYNC_1;
      2: return SYNC_2;
      3: return SYNC_3;
      4: return {VERSION_BITS, scid[7:2]};
      5: return {scid[1:0], vcid};
      6: return frame_seq[23:16];
      7: return frame_seq[15:8];
      8: return frame_seq[7:0];
      12: return {5'd0, rdy_ptr[10:8]};
      13: return rdy_ptr[7:0];
      default: ;
    endcase
    if (idx >= HDR_BYTES && idx - HDR_BYTES < int'(rdy_cnt)) return zone_mem[rd_base + idx - HDR_BYTES];
    return 8'h00;
  endfunction

  task automatic build_step(input req_t rq, output result_t res);
    res = '0;
    case (rq.op)
      OP_PUSH: begin
        if (!zone_held && fill_cnt < ZONE_BYTES) begin
          zone_mem[(fill_bank ? ZONE_BYTES : 0) + fill_cnt] = rq.data;
          if (rq.start && fill_ptr == NO_HEADER) fill_ptr = PTR_W'(fill_cnt);
          fill_cnt = fill_cnt + 1'b1;
          if (fill_cnt >= ZONE_BYTES) close_zone();
          res.accepted = 1'b1;
        end
      end
      OP_FLUSH: begin
        if (!zone_held) begin
          if (fill_cnt != 0) close_zone();
          res.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (zone_ready) begin
          res.out_byte  = frame_octet(emit_idx);
          res.out_valid = 1'b1;
          emit_idx = emit_idx + 1'b1;
          if (emit_idx >= FRAME_BYTES) begin
            res.frame_last = 1'b1;
            emit_idx   = '0;
            frame_seq  = frame_seq + 1'b1;
            zone_ready = 1'b0;
            if (zone_held) hand_over();
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic add_req(input op_t op, input logic [7:0] data, input logic start);
    req_t rq;
    rq.op    = op;
    rq.data  = data;
    rq.start = start;
    frame_reqs.insert(frame_reqs.size(), rq);
    queued++;
  endtask

  // hdr >= len gives a zone with no packet start
  task automatic add_zone(input int len, input int hdr);
    for (int i = 0; i < len; i++) begin
      add_req(OP_PUSH, 8'($urandom), i == hdr || (i > hdr && $urandom_range(3) == 0));
    end
  endtask

  task automatic add_reads(input int len);
    repeat (len) add_req(OP_READ, 8'($urandom), 1'($urandom));
  endtask

  task automatic write_regs(input logic [7:0] sc, input logic [5:0] vc);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SPACECRAFT;
    cfg_wdata <= sc;
    @(posedge clk);
    cfg_idx   <= REG_CHANNEL;
    cfg_wdata <= {2'($urandom), vc};
    @(posedge clk);
    cfg_we    <= 1'b0;
    scid = sc;
    vcid = vc;
  endtask

  task automatic wait_idle();
    while (frame_reqs.size() != 0 || in_ch.valid || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int items);
    int stop;
    int pick;
    int len;
    stop = queued + items;
    while (queued < stop) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
        add_zone(len, $urandom_range(len + len / 2));
        if ($urandom_range(99) < 85) add_req(OP_FLUSH, 8'($urandom), 1'($urandom));
      end else if (pick < 75) begin
        add_reads(($urandom_range(19) == 0) ? FRAME_BYTES : $urandom_range(1, 48));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) add_req(op_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end else begin
        // fill both banks, then knock on the door
        add_zone($urandom_range(1, 3), 0);
        add_req(OP_FLUSH, 8'($urandom), 1'($urandom));
        add_zone($urandom_range(1, 3), 1);
        add_req(OP_FLUSH, 8'($urandom), 1'($urandom));
        add_zone(2, 0);
        add_req(OP_FLUSH, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin : drive
    req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (frame_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = frame_reqs.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= nxt.op;
        in_ch.data_byte    <= nxt.data;
        in_ch.packet_start <= nxt.start;
      end else begin
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= 2'($urandom);
        in_ch.data_byte    <= 8'($urandom);
        in_ch.packet_start <= 1'($urandom);
      end
    end
  end

  always @(posedge clk) begin : observe
    req_t    rq;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (in_ch.valid && in_ch.ready) begin
        rq.op    = op_t'(in_ch.operation);
        rq.data  = in_ch.data_byte;
        rq.start = in_ch.packet_start;
        build_step(rq, want);
        due_results.insert(due_results.size(), want);
        n_transfers++;
        if ((rq.op == OP_PUSH || rq.op == OP_FLUSH) && !want.accepted) n_refused++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte %h valid %b last %b acc %b",
                   $time, out_ch.out_byte, out_ch.out_valid, out_ch.frame_last, out_ch.accepted);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("out_valid", 8'(want.out_valid), 8'(out_ch.out_valid));
          check_field("frame_last", 8'(want.frame_last), 8'(out_ch.frame_last));
          check_field("accepted", 8'(want.accepted), 8'(out_ch.accepted));
          if (want.frame_last) n_frames++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int hdr;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_NONE;
    in_ch.data_byte    = 8'h00;
    in_ch.packet_start = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values; a zone closed by filling with a pointer above 255,
    // a second zone held behind it, refused requests, then the whole frame read out
    send_idle_pct = 13;
    recv_idle_pct = 70;
    add_req(OP_READ, 8'hFF, 1'b1);
    add_req(OP_NONE, 8'hFF, 1'b1);
    add_req(OP_FLUSH, 8'h00, 1'b0);
    hdr = $urandom_range(256, ZONE_BYTES - 1);
    add_zone(ZONE_BYTES, hdr);
    add_req(OP_PUSH, 8'h5A, 1'b1);
    add_req(OP_PUSH, 8'hA5, 1'b0);
    add_req(OP_FLUSH, 8'h00, 1'b0);
    add_req(OP_PUSH, 8'h12, 1'b1);
    add_req(OP_FLUSH, 8'h00, 1'b0);
    add_reads(FRAME_BYTES);
    wait_idle();

    write_regs(8'hFF, 6'd63);
    add_reads(HDR_BYTES);
    run_phase(PHASE_ITEMS);
    wait_idle();

    write_regs(8'h00, 6'd0);
    send_idle_pct = 70;
    recv_idle_pct = 13;
    run_phase(PHASE_ITEMS);
    wait_idle();

    write_regs(8'($urandom), 6'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(PHASE_ITEMS);
    wait_idle();

    $display("%0d requests transferred, %0d frames read out, %0d pushes/flushes refused",
             n_transfers, n_frames, n_refused);
    $display("reset and three written register settings, both idling mixes and a full-rate stretch, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vmfb_pkg.sv
rtl/vmfb_if.sv
rtl/vmfb_front.sv
rtl/vmfb_back.sv
rtl/vcdu_mpdu_frame_builder.sv
rtl/vmfb_checker.sv
dv/tb_vcdu_mpdu_frame_builder.sv
